// File: rtl/core/swsem_pkg.sv
// ----------------------------------------------------------------------------
// swsem_pkg
// Shared types, constants and helper functions of the shape wipe mixer.
// ----------------------------------------------------------------------------
package swsem_pkg;

   localparam int PIX_W      = 64;
   localparam int CH_W       = 16;
   localparam int CH_N       = 4;
   localparam int PAT_W      = 8;
   localparam int COL_W      = 3 * PAT_W;
   localparam int CELL_N     = 9;
   localparam int CNT_W      = 4;
   localparam int WGT_W      = 17;
   localparam int PROD_W     = 33;
   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 64;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_WIPE_DIRECTION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOFT_EDGE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_LAYOUT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_THRESHOLD = 2'd3;

   localparam int CH_ALPHA_RGBA = 3;
   localparam int CH_ALPHA_AYUV = 0;

   localparam logic [WGT_W-1:0] FULL_WEIGHT = 17'd65536;

   typedef struct packed {
      logic             wipe_direction;
      logic             soft_edge;
      logic             pixel_layout;
      logic [PAT_W-1:0] edge_threshold;
   } mix_cfg_type;

   // cell index: column * 3 + row; column 0 left, row 0 above
   typedef struct packed {
      logic [CELL_N-1:0] hit;
      logic [CELL_N-1:0] inb;
      logic [PIX_W-1:0]  incoming;
      logic [PIX_W-1:0]  outgoing;
      logic              last;
   } mix_job_type;

   function automatic logic cell_passes(input mix_cfg_type cfg, input logic [PAT_W-1:0] pat);
      logic pass;
      if (cfg.wipe_direction) pass = (pat <= cfg.edge_threshold);
      else                    pass = (pat >= cfg.edge_threshold);
      return pass;
   endfunction

   function automatic logic [2:0] column_hits(input mix_cfg_type cfg, input logic [COL_W-1:0] pats);
      logic [2:0] hits;
      hits[0] = cell_passes(cfg, pats[PAT_W-1:0]);
      hits[1] = cell_passes(cfg, pats[2*PAT_W-1:PAT_W]);
      hits[2] = cell_passes(cfg, pats[3*PAT_W-1:2*PAT_W]);
      return hits;
   endfunction

   function automatic logic [CNT_W-1:0] count_cells(input logic [CELL_N-1:0] cells);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < CELL_N; i++) n = n + CNT_W'(cells[i]);
      return n;
   endfunction

   // round half up of count * 65536 / total
   function automatic logic [WGT_W-1:0] soft_weight(input logic [CNT_W-1:0] count,
                                                    input logic [CNT_W-1:0] total);
      logic [WGT_W-1:0] w;
      unique case ({total, count})
         8'h11: w = 17'd65536;
         8'h21: w = 17'd32768;
         8'h22: w = 17'd65536;
         8'h31: w = 17'd21845;
         8'h32: w = 17'd43691;
         8'h33: w = 17'd65536;
         8'h41: w = 17'd16384;
         8'h42: w = 17'd32768;
         8'h43: w = 17'd49152;
         8'h44: w = 17'd65536;
         8'h51: w = 17'd13107;
         8'h52: w = 17'd26214;
         8'h53: w = 17'd39322;
         8'h54: w = 17'd52429;
         8'h55: w = 17'd65536;
         8'h61: w = 17'd10923;
         8'h62: w = 17'd21845;
         8'h63: w = 17'd32768;
         8'h64: w = 17'd43691;
         8'h65: w = 17'd54613;
         8'h66: w = 17'd65536;
         8'h71: w = 17'd9362;
         8'h72: w = 17'd18725;
         8'h73: w = 17'd28087;
         8'h74: w = 17'd37449;
         8'h75: w = 17'd46811;
         8'h76: w = 17'd56174;
         8'h77: w = 17'd65536;
         8'h81: w = 17'd8192;
         8'h82: w = 17'd16384;
         8'h83: w = 17'd24576;
         8'h84: w = 17'd32768;
         8'h85: w = 17'd40960;
         8'h86: w = 17'd49152;
         8'h87: w = 17'd57344;
         8'h88: w = 17'd65536;
         8'h91: w = 17'd7282;
         8'h92: w = 17'd14564;
         8'h93: w = 17'd21845;
         8'h94: w = 17'd29127;
         8'h95: w = 17'd36409;
         8'h96: w = 17'd43691;
         8'h97: w = 17'd50972;
         8'h98: w = 17'd58254;
         8'h99: w = 17'd65536;
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

// File: rtl/core/swsem_front.sv
// ----------------------------------------------------------------------------
// swsem_front
// Column window tracking: accepts items, keeps the pending column and its
// left neighbour, classifies the 3x3 window cells and issues mix jobs.
// ----------------------------------------------------------------------------
module swsem_front (
   input  logic                                clock,
   input  logic                                reset,
   input  swsem_pkg::mix_cfg_type              cfg,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [swsem_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                push,
   output swsem_pkg::mix_job_type              push_job,
   input  logic                                full
);
   import swsem_pkg::*;

   logic [COL_W-1:0] win0_ff, win0_in, win1_ff, win1_in;
   logic [PIX_W-1:0] pend_in_ff, pend_in_in, pend_out_ff, pend_out_in;
   logic [1:0]       flags_ff, flags_in;
   logic             left_ff, left_in, pend_v_ff, pend_v_in, flush_ff, flush_in;

   logic [COL_W-1:0] pats;
   logic [1:0]       flags;
   logic             item_acc, right_valid;
   logic [2:0]       col_inb;

   assign pats  = req_tdata[COL_W-1:0];
   assign flags = req_tdata[COL_W+1:COL_W];

   assign req_tready  = !flush_ff && !full;
   assign item_acc    = req_tvalid && req_tready;
   assign push        = flush_ff ? !full : (item_acc && pend_v_ff);
   assign right_valid = !flush_ff && !req_tuser;
   assign col_inb     = {flags_ff[1], 1'b1, flags_ff[0]};

   always_comb begin
      push_job.inb      = {right_valid ? col_inb : 3'b000, col_inb,
                           left_ff ? col_inb : 3'b000};
      push_job.hit      = {column_hits(cfg, pats), column_hits(cfg, win1_ff),
                           column_hits(cfg, win0_ff)} & push_job.inb;
      push_job.incoming = pend_in_ff;
      push_job.outgoing = pend_out_ff;
      push_job.last     = !right_valid;
   end

   always_comb begin
      win0_in     = win0_ff;
      win1_in     = win1_ff;
      pend_in_in  = pend_in_ff;
      pend_out_in = pend_out_ff;
      flags_in    = flags_ff;
      left_in     = left_ff;
      pend_v_in   = pend_v_ff;
      flush_in    = flush_ff;
      if (flush_ff) begin
         if (!full) begin
            pend_v_in = 1'b0;
            left_in   = 1'b0;
            flush_in  = 1'b0;
         end
      end else if (item_acc) begin
         win0_in     = win1_ff;
         left_in     = pend_v_ff && !req_tuser;
         win1_in     = pats;
         flags_in    = flags;
         pend_in_in  = req_tdata[COL_W+2+PIX_W-1:COL_W+2];
         pend_out_in = req_tdata[COL_W+2+2*PIX_W-1:COL_W+2+PIX_W];
         pend_v_in   = 1'b1;
         flush_in    = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      win0_ff     <= win0_in;
      win1_ff     <= win1_in;
      pend_in_ff  <= pend_in_in;
      pend_out_ff <= pend_out_in;
      flags_ff    <= flags_in;
      if (reset) begin
         left_ff   <= 1'b0;
         pend_v_ff <= 1'b0;
         flush_ff  <= 1'b0;
      end else begin
         left_ff   <= left_in;
         pend_v_ff <= pend_v_in;
         flush_ff  <= flush_in;
      end
   end

   a_flush_has_column: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> pend_v_ff)
      else $error("row flush without a pending column");

   a_finish_flushes: assert property (@(posedge clock) disable iff (reset)
      (item_acc && req_tlast) |=> (flush_ff && !req_tready))
      else $error("row end did not start a flush");

endmodule

// File: rtl/core/swsem_queue.sv
// ----------------------------------------------------------------------------
// swsem_queue
// Short job queue between the window front end and the blend back end.
// ----------------------------------------------------------------------------
module swsem_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  swsem_pkg::mix_job_type push_job,
   output logic                   full,
   input  logic                   pop,
   output swsem_pkg::mix_job_type head_job,
   output logic                   head_valid
);
   import swsem_pkg::*;

   mix_job_type       entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_job;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("job queue underflow");

endmodule

// File: rtl/core/swsem_back.sv
// ----------------------------------------------------------------------------
// swsem_back
// Blend pipeline: cell count and weight lookup, channel products, final sum
// and alpha selection into the output register.
// ----------------------------------------------------------------------------
module swsem_back (
   input  logic                              clock,
   input  logic                              reset,
   input  swsem_pkg::mix_cfg_type            cfg,
   input  logic                              head_valid,
   input  swsem_pkg::mix_job_type            head_job,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [swsem_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast
);
   import swsem_pkg::*;

   logic              v1_ff, v2_ff, v3_ff;
   logic              adv1, adv2, adv3;

   logic [CNT_W-1:0]  count, total;
   logic [WGT_W-1:0]  wgt_in, wgt_ff, inv;
   logic              byp1_in, byp1_ff, last1_ff;
   logic [PIX_W-1:0]  base1_in, base1_ff, in1_ff;

   logic [PROD_W-1:0] pa_in [CH_N];
   logic [PROD_W-1:0] pb_in [CH_N];
   logic [PROD_W-1:0] pa_ff [CH_N];
   logic [PROD_W-1:0] pb_ff [CH_N];
   logic              byp2_ff, last2_ff;
   logic [PIX_W-1:0]  base2_ff;

   logic [PROD_W-1:0] sum;
   logic [PIX_W-1:0]  pix3_in, pix3_ff;
   logic              last3_ff;

   assign adv3 = !v3_ff || rsp_tready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign pop  = head_valid && adv1;

   always_comb begin
      count    = count_cells(head_job.hit);
      total    = count_cells(head_job.inb);
      wgt_in   = soft_weight(count, total);
      byp1_in  = !cfg.soft_edge || (count == '0);
      if (!cfg.soft_edge && head_job.hit[4]) base1_in = head_job.incoming;
      else                                   base1_in = head_job.outgoing;
   end

   assign inv = FULL_WEIGHT - wgt_ff;

   always_comb begin
      for (int ch = 0; ch < CH_N; ch++) begin
         pa_in[ch] = PROD_W'(in1_ff[ch*CH_W +: CH_W]) * PROD_W'(wgt_ff);
         pb_in[ch] = PROD_W'(base1_ff[ch*CH_W +: CH_W]) * PROD_W'(inv);
      end
   end

   always_comb begin
      sum     = '0;
      pix3_in = base2_ff;
      for (int ch = 0; ch < CH_N; ch++) begin
         sum = pa_ff[ch] + pb_ff[ch];
         if (!byp2_ff && !(cfg.pixel_layout ? (ch == CH_ALPHA_AYUV) : (ch == CH_ALPHA_RGBA)))
            pix3_in[ch*CH_W +: CH_W] = sum[2*CH_W-1:CH_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         wgt_ff   <= wgt_in;
         byp1_ff  <= byp1_in;
         base1_ff <= base1_in;
         in1_ff   <= head_job.incoming;
         last1_ff <= head_job.last;
      end
      if (adv2) begin
         for (int ch = 0; ch < CH_N; ch++) begin
            pa_ff[ch] <= pa_in[ch];
            pb_ff[ch] <= pb_in[ch];
         end
         byp2_ff  <= byp1_ff;
         base2_ff <= base1_ff;
         last2_ff <= last1_ff;
      end
      if (adv3) begin
         pix3_ff  <= pix3_in;
         last3_ff <= last2_ff;
      end
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= head_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = pix3_ff;
   assign rsp_tlast  = last3_ff;

endmodule

// File: rtl/core/shape_wipe_soft_edge_mixer_unit.sv
// ----------------------------------------------------------------------------
// shape_wipe_soft_edge_mixer_unit
// Wipe transition mixer with soft 3x3 edges for 16-bit four-channel pixels.
//
//   channel | direction | fields
//   --------+-----------+----------------------------------------------------
//   req     | in        | pattern bytes, row flags, pixel pair, row markers
//   rsp     | out       | mixed pixel, row_last
//   csr     | in        | register index and write data
//
// One item per cycle while the job queue has room; a row end holds req for the flush job.
// A result passes through the queue, weight stage, product stage and output
// register after the column to its right is taken.
// Reset clears the window, queue and pipeline valids; config registers go to zero.
// A stalled rsp side fills the four-entry job queue before req is held.
// ----------------------------------------------------------------------------
module shape_wipe_soft_edge_mixer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pattern_above, pattern_center, pattern_below, above_exists,
   // below_exists, incoming_pixel, outgoing_pixel, zero fill
   input  logic [swsem_pkg::REQ_DATA_W-1:0]    req_tdata,
   // row_begin
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // mixed_pixel
   output logic [swsem_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [swsem_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [swsem_pkg::CSR_DATA_W-1:0]    csr_data
);
   import swsem_pkg::*;

   mix_cfg_type cfg_ff, cfg_in;
   logic        push, full, pop, head_valid;
   mix_job_type push_job, head_job;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WIPE_DIRECTION: cfg_in.wipe_direction = csr_data[0];
            CSR_SOFT_EDGE:      cfg_in.soft_edge      = csr_data[0];
            CSR_PIXEL_LAYOUT:   cfg_in.pixel_layout   = csr_data[0];
            CSR_EDGE_THRESHOLD: cfg_in.edge_threshold = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else       cfg_ff <= cfg_in;
   end

   swsem_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_job   (push_job),
      .full       (full)
   );

   swsem_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_job   (head_job),
      .head_valid (head_valid)
   );

   swsem_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shape wipe soft edge mixer. A directed table
// covers reset, threshold extremes, both wipe directions, soft and hard
// mixing, both pixel layouts, short frames, count zero, unfinished rows and
// rows without a begin marker. Random frames and broken rows follow under a
// series of register settings. A behavioral model of the window predicts
// the mixed pixels of untyped rows, and all results are checked in order as
// they leave the block. Both sides idle at random, with one long output stall.
// ----------------------------------------------------------------------------
module tb;
   import swsem_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 123;
   localparam logic [63:0] ONES = '1;
   localparam logic [63:0] PIX_A = 64'h0123_4567_89AB_CDEF;
   localparam logic [63:0] PIX_B = 64'hFEDC_BA98_7654_3210;

   localparam mix_cfg_type CFG_RESET     = '{1'b0, 1'b0, 1'b0, 8'd0};
   localparam mix_cfg_type CFG_HARD_HI   = '{1'b0, 1'b0, 1'b0, 8'd255};
   localparam mix_cfg_type CFG_HARD_REV  = '{1'b1, 1'b0, 1'b0, 8'd0};
   localparam mix_cfg_type CFG_SOFT_MID  = '{1'b0, 1'b1, 1'b0, 8'd128};
   localparam mix_cfg_type CFG_SOFT_AYUV = '{1'b1, 1'b1, 1'b1, 8'd255};
   localparam mix_cfg_type CFG_SOFT_NONE = '{1'b0, 1'b1, 1'b0, 8'd255};

   typedef struct packed {
      logic [7:0]  above;
      logic [7:0]  center;
      logic [7:0]  below;
      logic        above_exists;
      logic        below_exists;
      logic [63:0] incoming;
      logic [63:0] outgoing;
      logic        row_begin;
      logic        row_finish;
   } column_type;

   typedef struct {
      logic [63:0] pixel;
      logic        last;
   } mixed_type;

   typedef struct {
      mix_cfg_type setting;
      column_type  col;
      logic        typed;
      logic [63:0] want_pixel;
      logic        want_last;
   } directed_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   shape_wipe_soft_edge_mixer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // model of the register set and the column window
   mix_cfg_type cfg;
   logic [23:0] win_left;
   logic [23:0] win_mid;
   logic [63:0] held_in;
   logic [63:0] held_out;
   logic [1:0]  held_flags;
   logic        left_ok;
   logic        held_ok;

   mixed_type        mix_expected[$];
   mixed_type        fresh_mixes[$];
   directed_row_type directed_rows[$];
   mixed_type        oldest;

   int  items_sent;
   int  results_seen;
   int  row_ends;
   int  soft_results;
   int  failures;
   int  cycles;
   int  stall_left;
   bit  stall_done;
   bit  open_row;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results pending", cycles,
                  mix_expected.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic bit quiet_window();
      return items_sent >= 500 && items_sent < 700;
   endfunction

   function automatic logic passes(input logic [7:0] v);
      return cfg.wipe_direction ? (v <= cfg.edge_threshold) : (v >= cfg.edge_threshold);
   endfunction

   function automatic void tally(input logic [23:0] pats, input logic [1:0] flags,
                                 inout int hits, inout int cells);
      if (flags[0]) begin
         cells++;
         if (passes(pats[7:0])) hits++;
      end
      cells++;
      if (passes(pats[15:8])) hits++;
      if (flags[1]) begin
         cells++;
         if (passes(pats[23:16])) hits++;
      end
   endfunction

   function automatic logic [63:0] mix_held(input logic right_ok, input logic [23:0] right_pats);
      int hits;
      int cells;
      int alpha;
      longint unsigned w;
      longint unsigned a;
      longint unsigned b;
      logic [63:0] r;
      hits = 0;
      cells = 0;
      r = '0;
      if (!cfg.soft_edge) return passes(win_mid[15:8]) ? held_in : held_out;
      if (left_ok) tally(win_left, held_flags, hits, cells);
      tally(win_mid, held_flags, hits, cells);
      if (right_ok) tally(right_pats, held_flags, hits, cells);
      if (hits == 0) return held_out;
      w = (longint'(hits) * 2 * 65536 + cells) / (2 * cells);
      alpha = cfg.pixel_layout ? CH_ALPHA_AYUV : CH_ALPHA_RGBA;
      for (int ch = 0; ch < CH_N; ch++) begin
         a = 64'(held_in[16*ch +: 16]);
         b = 64'(held_out[16*ch +: 16]);
         if (ch == alpha) r[16*ch +: 16] = b[15:0];
         else r[16*ch +: 16] = 16'((a * w + b * (65536 - w)) >> 16);
      end
      return r;
   endfunction

   // advance the window by one column, leaving its results in fresh_mixes
   function automatic void step_mixer(input column_type c);
      logic [23:0] pats;
      pats = {c.below, c.center, c.above};
      fresh_mixes.delete();
      if (c.row_begin && held_ok) begin
         fresh_mixes.push_back('{mix_held(1'b0, '0), 1'b1});
         held_ok = 1'b0;
         left_ok = 1'b0;
      end
      if (held_ok) begin
         fresh_mixes.push_back('{mix_held(1'b1, pats), 1'b0});
         win_left = win_mid;
         left_ok = 1'b1;
      end else begin
         left_ok = 1'b0;
      end
      win_mid = pats;
      held_in = c.incoming;
      held_out = c.outgoing;
      held_flags = {c.below_exists, c.above_exists};
      held_ok = 1'b1;
      if (c.row_finish) begin
         fresh_mixes.push_back('{mix_held(1'b0, '0), 1'b1});
         held_ok = 1'b0;
         left_ok = 1'b0;
      end
   endfunction

   task automatic wait_drained();
      while (mix_expected.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WIPE_DIRECTION: cfg.wipe_direction = val[0];
         CSR_SOFT_EDGE:      cfg.soft_edge = val[0];
         CSR_PIXEL_LAYOUT:   cfg.pixel_layout = val[0];
         CSR_EDGE_THRESHOLD: cfg.edge_threshold = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(input mix_cfg_type s);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (12) @(posedge clock);
      write_reg(CSR_WIPE_DIRECTION, {7'd0, s.wipe_direction});
      write_reg(CSR_SOFT_EDGE, {7'd0, s.soft_edge});
      write_reg(CSR_PIXEL_LAYOUT, {7'd0, s.pixel_layout});
      write_reg(CSR_EDGE_THRESHOLD, s.edge_threshold);
   endtask

   task automatic send_column(input column_type c, input logic typed,
                              input logic [63:0] want_pixel, input logic want_last);
      if (items_sent == 900) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         wait_drained();
      end
      while (!quiet_window() && $urandom_range(99) < 16) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, c.outgoing, c.incoming, c.below_exists, c.above_exists,
                    c.below, c.center, c.above};
      req_tuser <= c.row_begin;
      req_tlast <= c.row_finish;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      open_row = !c.row_finish;
      step_mixer(c);
      if (typed) mix_expected.push_back('{want_pixel, want_last});
      else foreach (fresh_mixes[i]) mix_expected.push_back(fresh_mixes[i]);
   endtask

   task automatic add_row(input mix_cfg_type s, input logic [7:0] pa, input logic [7:0] pc,
                          input logic [7:0] pb, input logic ae, input logic be,
                          input logic [63:0] inc, input logic [63:0] outg,
                          input logic rb, input logic rf, input logic typed,
                          input logic [63:0] want_pixel, input logic want_last);
      directed_row_type r;
      r.setting = s;
      r.col = '{pa, pc, pb, ae, be, inc, outg, rb, rf};
      r.typed = typed;
      r.want_pixel = want_pixel;
      r.want_last = want_last;
      directed_rows.push_back(r);
   endtask

   function automatic logic [63:0] rand_pixel();
      case ($urandom_range(9))
         0: return '0;
         1: return ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [7:0] rand_pattern();
      int v;
      if ($urandom_range(1)) return 8'($urandom_range(255));
      v = int'(cfg.edge_threshold) + int'($urandom_range(4)) - 2;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   function automatic column_type rand_column(input logic ae, input logic be,
                                              input logic rb, input logic rf);
      column_type c;
      c = '{rand_pattern(), rand_pattern(), rand_pattern(), ae, be,
            rand_pixel(), rand_pixel(), rb, rf};
      return c;
   endfunction

   task automatic run_phase(input int p);
      mix_cfg_type s;
      int n;
      int rows;
      int width;
      s.wipe_direction = p[0];
      s.soft_edge = (p % 5) != 0;
      s.pixel_layout = p[1];
      case (p % 4)
         0: s.edge_threshold = 8'd0;
         3: s.edge_threshold = 8'd255;
         default: s.edge_threshold = 8'($urandom_range(1, 254));
      endcase
      apply_setting(s);
      n = 0;
      while (n < PHASE_ITEMS) begin
         if ($urandom_range(9) < 8) begin
            // well-formed frame
            rows = $urandom_range(1, 4);
            width = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            for (int r = 0; r < rows; r++)
               for (int c = 0; c < width; c++) begin
                  send_column(rand_column(r > 0, r < rows - 1, c == 0, c == width - 1),
                              1'b0, '0, 1'b0);
                  n++;
               end
         end else begin
            repeat ($urandom_range(1, 6)) begin
               send_column(rand_column(1'($urandom_range(1)), 1'($urandom_range(1)),
                                       $urandom_range(3) == 0, $urandom_range(3) == 0),
                           1'b0, '0, 1'b0);
               n++;
            end
         end
      end
      if (open_row) send_column(rand_column(1'b1, 1'b1, 1'b0, 1'b1), 1'b0, '0, 1'b0);
   endtask

   // output side: random stalls, one long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!stall_done && items_sent >= 300) begin
            stall_left = 80;
            stall_done = 1'b1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet_window() || ($urandom_range(99) >= 16);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mix_expected.size() == 0) begin
            $error("unexpected item: mixed_pixel %h row_last %b", rsp_tdata, rsp_tlast);
            failures++;
         end else begin
            oldest = mix_expected.pop_front();
            results_seen++;
            if (oldest.last) row_ends++;
            if (cfg.soft_edge) soft_results++;
            if (rsp_tdata !== oldest.pixel) begin
               $error("mixed_pixel expected %h actual %h", oldest.pixel, rsp_tdata);
               failures++;
            end
            if (rsp_tlast !== oldest.last) begin
               $error("row_last expected %b actual %b", oldest.last, rsp_tlast);
               failures++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_WIPE_DIRECTION;
      csr_data = '0;
      cfg = CFG_RESET;
      win_left = '0;
      win_mid = '0;
      held_in = '0;
      held_out = '0;
      held_flags = '0;
      left_ok = 1'b0;
      held_ok = 1'b0;

      // reset values: every cell passes, one-column rows
      add_row(CFG_RESET, 8'h00, 8'h00, 8'h00, 0, 0, ONES, '0, 1, 1, 1, ONES, 1);
      add_row(CFG_RESET, 8'hFF, 8'hFF, 8'hFF, 1, 1, '0, ONES, 1, 1, 1, '0, 1);
      // hard switch at the threshold extremes
      add_row(CFG_HARD_HI, 8'h00, 8'hFF, 8'h00, 1, 1, PIX_A, PIX_B, 1, 1, 1, PIX_A, 1);
      add_row(CFG_HARD_HI, 8'hFF, 8'hFE, 8'hFF, 1, 1, PIX_A, PIX_B, 1, 1, 1, PIX_B, 1);
      add_row(CFG_HARD_REV, 8'hFF, 8'h00, 8'hFF, 1, 1, PIX_A, PIX_B, 1, 1, 1, PIX_A, 1);
      add_row(CFG_HARD_REV, 8'h00, 8'h01, 8'h00, 1, 1, PIX_A, PIX_B, 1, 1, 1, PIX_B, 1);
      // full 3x3 windows
      add_row(CFG_SOFT_MID, 8'h80, 8'h7F, 8'hFF, 1, 1, PIX_A, PIX_B, 1, 0, 0, '0, 0);
      add_row(CFG_SOFT_MID, 8'h7F, 8'h80, 8'h00, 1, 1, ONES, '0, 0, 0, 0, '0, 0);
      add_row(CFG_SOFT_MID, 8'hFF, 8'hFF, 8'h7F, 1, 1, PIX_B, PIX_A, 0, 1, 0, '0, 0);
      // row cut short by the next row begin
      add_row(CFG_SOFT_MID, 8'h90, 8'h10, 8'h80, 0, 1, PIX_A, ONES, 1, 0, 0, '0, 0);
      add_row(CFG_SOFT_MID, 8'h20, 8'hA0, 8'h30, 0, 1, ONES, PIX_B, 0, 0, 0, '0, 0);
      add_row(CFG_SOFT_MID, 8'h81, 8'h00, 8'hFF, 1, 0, PIX_B, '0, 1, 0, 0, '0, 0);
      add_row(CFG_SOFT_MID, 8'h00, 8'hC0, 8'h00, 1, 0, '0, PIX_A, 0, 1, 0, '0, 0);
      // row without a begin marker
      add_row(CFG_SOFT_MID, 8'h7F, 8'h7F, 8'h80, 1, 1, PIX_A, PIX_B, 0, 0, 0, '0, 0);
      add_row(CFG_SOFT_MID, 8'h80, 8'h00, 8'h00, 1, 1, ONES, '0, 0, 1, 0, '0, 0);
      // one-row and one-column frames, AYUV
      add_row(CFG_SOFT_AYUV, 8'h00, 8'h33, 8'h00, 0, 0, ONES, '0, 1, 1, 0, '0, 0);
      add_row(CFG_SOFT_AYUV, 8'h00, 8'hFF, 8'h00, 1, 0, PIX_A, PIX_B, 1, 0, 0, '0, 0);
      add_row(CFG_SOFT_AYUV, 8'hFF, 8'h00, 8'h00, 1, 0, '0, ONES, 0, 1, 0, '0, 0);
      // no cell passes: outgoing kept
      add_row(CFG_SOFT_NONE, 8'h00, 8'hFE, 8'h00, 1, 1, PIX_A, PIX_B, 1, 1, 1, PIX_B, 1);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].setting != cfg) apply_setting(directed_rows[i].setting);
         send_column(directed_rows[i].col, directed_rows[i].typed,
                     directed_rows[i].want_pixel, directed_rows[i].want_last);
      end
      for (int p = 0; p < PHASES; p++) run_phase(p);

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (mix_expected.size() != 0) failures++;

      $display("sent %0d columns under %0d register settings", items_sent, PHASES + 6);
      $display("checked %0d mixed pixels, %0d row ends, %0d in soft mode",
               results_seen, row_ends, soft_results);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/swsem_pkg.sv
rtl/core/swsem_front.sv
rtl/core/swsem_queue.sv
rtl/core/swsem_back.sv
rtl/core/shape_wipe_soft_edge_mixer_unit.sv
test/tb.sv
